// ===== hw/rtl/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// blr_pkg
// shared constants for the line rasterizer: configuration register map,
// command codes and fixed field widths
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam int COLOR_W    = 24;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_PEN_COLOR   = 3'd0;
	localparam reg_idx_t REG_CLIP_LEFT   = 3'd1;
	localparam reg_idx_t REG_CLIP_TOP    = 3'd2;
	localparam reg_idx_t REG_CLIP_RIGHT  = 3'd3;
	localparam reg_idx_t REG_CLIP_BOTTOM = 3'd4;

	typedef enum logic {CMD_START = 1'b0, CMD_NEXT = 1'b1} line_op_t;

endpackage

// ===== hw/rtl/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// path: input transfer to setup register, then result register
// throughput: one command and one pixel per cycle while the output is not stalled;
//   the error update feeds the line state back into the next step
// reset: asynchronous, no line active, clip rectangle back to its reset edges
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// stream in
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: start_x, start_y, end_x, end_y
	input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	// tuser: cmd
	input  logic [0:0]                        s_axis_tuser,
	// stream out
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: pixel_x, pixel_y, pixel_color
	output logic [((2*COORD_BITS+blr_pkg::COLOR_W+7)/8)*8-1:0] m_axis_tdata,
	// tuser: pixel_valid, inside_clip
	output logic [1:0]                        m_axis_tuser,
	output logic                              m_axis_tlast,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [blr_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [blr_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [blr_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int C     = COORD_BITS;
	localparam int E     = COORD_BITS + 2;

	logic [blr_pkg::COLOR_W-1:0] pen_color;
	logic signed [C-1:0]         clip_left, clip_top, clip_right, clip_bottom;

	blr_apb_regs #(.COORD_BITS(COORD_BITS)) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.pen_color   (pen_color),
		.clip_left   (clip_left),
		.clip_top    (clip_top),
		.clip_right  (clip_right),
		.clip_bottom (clip_bottom)
	);

	// line setup ahead of the first register
	logic signed [C-1:0] in_sx, in_sy, in_ex, in_ey;
	logic signed [C:0]   in_dx, in_dy;
	logic [C:0]          in_adx, in_ady;
	logic                in_xmaj;

	assign in_sx = s_axis_tdata[C-1:0];
	assign in_sy = s_axis_tdata[2*C-1:C];
	assign in_ex = s_axis_tdata[3*C-1:2*C];
	assign in_ey = s_axis_tdata[4*C-1:3*C];
	assign in_dx = {in_ex[C-1], in_ex} - {in_sx[C-1], in_sx};
	assign in_dy = {in_ey[C-1], in_ey} - {in_sy[C-1], in_sy};
	assign in_adx = in_dx[C] ? (~in_dx + 1'b1) : in_dx;
	assign in_ady = in_dy[C] ? (~in_dy + 1'b1) : in_dy;
	assign in_xmaj = in_adx > in_ady;

	logic                s1_valid;
	logic                cmd_s1;
	logic [C-1:0]        sx_s1, sy_s1, stop_s1;
	logic [C-1:0]        major_s1, minor_s1;
	logic                xmaj_s1, xneg_s1, yneg_s1;
	logic                out_valid_q;
	logic                adv;
	logic                in_xfer;

	assign adv           = s1_valid && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid || adv;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_xfer) begin
			s1_valid <= 1'b1;
		end else if (adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1   <= s_axis_tuser[0];
			sx_s1    <= in_sx;
			sy_s1    <= in_sy;
			stop_s1  <= in_xmaj ? in_ex : in_ey;
			major_s1 <= in_xmaj ? in_adx[C-1:0] : in_ady[C-1:0];
			minor_s1 <= in_xmaj ? in_ady[C-1:0] : in_adx[C-1:0];
			xmaj_s1  <= in_xmaj;
			xneg_s1  <= !(!in_dx[C] && (in_dx != '0));
			yneg_s1  <= !(!in_dy[C] && (in_dy != '0));
		end
	end

	// line state
	logic [C-1:0]        cur_x_q, cur_y_q, stop_q, major_q, minor_q;
	logic signed [E-1:0] err_q;
	logic                xneg_q, yneg_q, xmaj_q, active_q;

	logic                start;
	logic [C-1:0]        b_x, b_y, b_stop, b_major, b_minor;
	logic signed [E-1:0] b_err;
	logic                b_xneg, b_yneg, b_xmaj, b_active;

	assign start   = cmd_s1 == blr_pkg::CMD_START;
	assign b_x     = start ? sx_s1    : cur_x_q;
	assign b_y     = start ? sy_s1    : cur_y_q;
	assign b_stop  = start ? stop_s1  : stop_q;
	assign b_major = start ? major_s1 : major_q;
	assign b_minor = start ? minor_s1 : minor_q;
	assign b_xneg  = start ? xneg_s1  : xneg_q;
	assign b_yneg  = start ? yneg_s1  : yneg_q;
	assign b_xmaj  = start ? xmaj_s1  : xmaj_q;
	assign b_err   = start ? '0       : err_q;
	assign b_active = start ? (major_s1 != '0) : active_q;

	// one bresenham step
	logic signed [E-1:0] err_add, err_next;
	logic signed [E:0]   err_dbl, major_ext;
	logic                step_minor;
	logic signed [C:0]   xw, yw, x_inc, y_inc, x_n, y_n, stop_w;
	logic                done;
	logic                in_clip;

	assign err_add    = b_err + $signed({2'b00, b_minor});
	assign err_dbl    = {err_add, 1'b0};
	assign major_ext  = $signed({3'b000, b_major});
	assign step_minor = err_dbl >= major_ext;
	assign err_next   = step_minor ? (err_add - $signed({2'b00, b_major})) : err_add;

	assign xw     = {b_x[C-1], b_x};
	assign yw     = {b_y[C-1], b_y};
	assign stop_w = {b_stop[C-1], b_stop};
	assign x_inc  = b_xneg ? (xw - 1'b1) : (xw + 1'b1);
	assign y_inc  = b_yneg ? (yw - 1'b1) : (yw + 1'b1);

	always_comb begin
		if (b_xmaj) begin
			x_n  = x_inc;
			y_n  = step_minor ? y_inc : yw;
			done = x_inc == stop_w;
		end else begin
			y_n  = y_inc;
			x_n  = step_minor ? x_inc : xw;
			done = y_inc == stop_w;
		end
	end

	assign in_clip = ($signed(b_x) >= clip_left) && ($signed(b_x) < clip_right) &&
		($signed(b_y) >= clip_top) && ($signed(b_y) < clip_bottom);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			stop_q   <= '0;
			major_q  <= '0;
			minor_q  <= '0;
			err_q    <= '0;
			xneg_q   <= 1'b0;
			yneg_q   <= 1'b0;
			xmaj_q   <= 1'b0;
			active_q <= 1'b0;
		end else if (adv) begin
			stop_q   <= b_stop;
			major_q  <= b_major;
			minor_q  <= b_minor;
			xneg_q   <= b_xneg;
			yneg_q   <= b_yneg;
			xmaj_q   <= b_xmaj;
			cur_x_q  <= b_active ? x_n[C-1:0] : b_x;
			cur_y_q  <= b_active ? y_n[C-1:0] : b_y;
			err_q    <= b_active ? err_next : b_err;
			active_q <= b_active && !done;
		end
	end

	// result register
	logic                        pix_valid_q, inside_q, last_q;
	logic [C-1:0]                pix_x_q, pix_y_q;
	logic [blr_pkg::COLOR_W-1:0] pix_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_valid_q <= b_active;
			pix_x_q     <= b_active ? b_x : '0;
			pix_y_q     <= b_active ? b_y : '0;
			pix_color_q <= b_active ? pen_color : '0;
			inside_q    <= b_active && in_clip;
			last_q      <= b_active && done;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[C-1:0]   = pix_x_q;
		m_axis_tdata[2*C-1:C] = pix_y_q;
		m_axis_tdata[2*C+blr_pkg::COLOR_W-1:2*C] = pix_color_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {inside_q, pix_valid_q};
	assign m_axis_tlast  = last_q;

	// checks
	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
		else $error("last mark on an empty result");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
		else $error("empty result carries data");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while both stages are stalled");

	a_active_has_delta: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (major_q != '0))
		else $error("active line with zero major delta");

endmodule

// ===== hw/rtl/blr_apb_regs.sv =====
// ----------------------------------------------------------------------------
// blr_apb_regs
// apb register file holding pen color and clip rectangle
// ----------------------------------------------------------------------------
module blr_apb_regs #(
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [blr_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [blr_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [blr_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [blr_pkg::COLOR_W-1:0]       pen_color,
	output logic signed [COORD_BITS-1:0]      clip_left,
	output logic signed [COORD_BITS-1:0]      clip_top,
	output logic signed [COORD_BITS-1:0]      clip_right,
	output logic signed [COORD_BITS-1:0]      clip_bottom
);

	localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam int PAD_W = blr_pkg::CFG_DATA_W - COORD_BITS;

	logic [blr_pkg::COLOR_W-1:0] pen_color_q;
	logic [COORD_BITS-1:0]       clip_left_q;
	logic [COORD_BITS-1:0]       clip_top_q;
	logic [COORD_BITS-1:0]       clip_right_q;
	logic [COORD_BITS-1:0]       clip_bottom_q;
	blr_pkg::reg_idx_t           idx;
	logic                        wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_color_q   <= '0;
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= COORD_MAX;
			clip_bottom_q <= COORD_MAX;
		end else if (wr_en) begin
			unique case (idx)
				blr_pkg::REG_PEN_COLOR:   pen_color_q   <= pwdata[blr_pkg::COLOR_W-1:0];
				blr_pkg::REG_CLIP_LEFT:   clip_left_q   <= pwdata[COORD_BITS-1:0];
				blr_pkg::REG_CLIP_TOP:    clip_top_q    <= pwdata[COORD_BITS-1:0];
				blr_pkg::REG_CLIP_RIGHT:  clip_right_q  <= pwdata[COORD_BITS-1:0];
				blr_pkg::REG_CLIP_BOTTOM: clip_bottom_q <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			blr_pkg::REG_PEN_COLOR:   prdata = {{(blr_pkg::CFG_DATA_W-blr_pkg::COLOR_W){1'b0}},
				pen_color_q};
			blr_pkg::REG_CLIP_LEFT:   prdata = {{PAD_W{1'b0}}, clip_left_q};
			blr_pkg::REG_CLIP_TOP:    prdata = {{PAD_W{1'b0}}, clip_top_q};
			blr_pkg::REG_CLIP_RIGHT:  prdata = {{PAD_W{1'b0}}, clip_right_q};
			blr_pkg::REG_CLIP_BOTTOM: prdata = {{PAD_W{1'b0}}, clip_bottom_q};
			default:                  prdata = '0;
		endcase
	end

	assign pen_color   = pen_color_q;
	assign clip_left   = clip_left_q;
	assign clip_top    = clip_top_q;
	assign clip_right  = clip_right_q;
	assign clip_bottom = clip_bottom_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the line rasterizer pixel by pixel against an in-bench model of the
// integer line walk, clip test and last-pixel mark; commands stream in with
// random bursts and gaps, pixels are taken with random back pressure, and the
// pen color and clip edges are rewritten between phases while the block idles
// ----------------------------------------------------------------------------
module testbench;

	localparam int COORD_BITS     = 12;
	localparam int COORD_MIN      = -2048;
	localparam int COORD_MAX      = 2047;
	localparam int LATENCY        = 2;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 160;
	localparam blr_pkg::reg_idx_t REG_UNMAPPED = 3'd7;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		blr_pkg::line_op_t op;
		coord_t            sx;
		coord_t            sy;
		coord_t            ex;
		coord_t            ey;
	} line_cmd_t;

	typedef struct packed {
		logic                        valid;
		coord_t                      x;
		coord_t                      y;
		logic [blr_pkg::COLOR_W-1:0] color;
		logic                        in_clip;
		logic                        last;
	} pixel_t;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	// tdata: start_x, start_y, end_x, end_y
	logic [47:0]                    s_axis_tdata = '0;
	// tuser: cmd
	logic [0:0]                     s_axis_tuser = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// tdata: pixel_x, pixel_y, pixel_color
	logic [47:0]                    m_axis_tdata;
	// tuser: pixel_valid, inside_clip
	logic [1:0]                     m_axis_tuser;
	logic                           m_axis_tlast;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [blr_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [blr_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [blr_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;

	bresenham_line_rasterizer #(
		.COORD_BITS(COORD_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	line_cmd_t pending_cmds[$];
	pixel_t    expected_pixels[$];
	int        mismatches = 0;

	// pen, clip edges and line walk state
	logic [blr_pkg::COLOR_W-1:0] pen_rgb = '0;
	int clip_l = 0, clip_t = 0, clip_r = 2047, clip_b = 2047;
	int pos_x = 0, pos_y = 0, stop_at = 0, err_acc = 0, major_d = 0, minor_d = 0;
	bit x_back = 0, y_back = 0, along_x = 0, drawing = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic rasterize_step(input line_cmd_t c);
		int dx, dy, adx, ady;
		pixel_t px;
		px = '0;
		if (c.op == blr_pkg::CMD_START) begin
			dx = int'(c.ex) - int'(c.sx);
			dy = int'(c.ey) - int'(c.sy);
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			x_back = !(dx > 0);
			y_back = !(dy > 0);
			pos_x = c.sx;
			pos_y = c.sy;
			err_acc = 0;
			along_x = adx > ady;
			major_d = along_x ? adx : ady;
			minor_d = along_x ? ady : adx;
			stop_at = along_x ? c.ex : c.ey;
			drawing = major_d != 0;
		end
		if (drawing) begin
			px.valid = 1'b1;
			px.x = coord_t'(pos_x);
			px.y = coord_t'(pos_y);
			px.color = pen_rgb;
			px.in_clip = pos_x >= clip_l && pos_x < clip_r &&
				pos_y >= clip_t && pos_y < clip_b;
			err_acc += minor_d;
			if (along_x) begin
				pos_x += x_back ? -1 : 1;
				if (2 * err_acc >= major_d) begin
					pos_y += y_back ? -1 : 1;
					err_acc -= major_d;
				end
				drawing = pos_x != stop_at;
			end else begin
				pos_y += y_back ? -1 : 1;
				if (2 * err_acc >= major_d) begin
					pos_x += x_back ? -1 : 1;
					err_acc -= major_d;
				end
				drawing = pos_y != stop_at;
			end
			pos_x = coord_t'(pos_x);
			pos_y = coord_t'(pos_y);
			px.last = !drawing;
		end
		expected_pixels.push_back(px);
	endtask

	task automatic queue_cmd(input blr_pkg::line_op_t op, input int sx, input int sy,
			input int ex, input int ey);
		line_cmd_t c;
		c.op = op;
		c.sx = coord_t'(sx);
		c.sy = coord_t'(sy);
		c.ex = coord_t'(ex);
		c.ey = coord_t'(ey);
		pending_cmds.push_back(c);
	endtask

	function automatic int clamp_coord(input int v);
		return v < COORD_MIN ? COORD_MIN : (v > COORD_MAX ? COORD_MAX : v);
	endfunction

	task automatic write_reg(input blr_pkg::reg_idx_t idx,
			input logic [blr_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			blr_pkg::REG_PEN_COLOR:   pen_rgb = value[blr_pkg::COLOR_W-1:0];
			blr_pkg::REG_CLIP_LEFT:   clip_l = coord_t'(value);
			blr_pkg::REG_CLIP_TOP:    clip_t = coord_t'(value);
			blr_pkg::REG_CLIP_RIGHT:  clip_r = coord_t'(value);
			blr_pkg::REG_CLIP_BOTTOM: clip_b = coord_t'(value);
			default: ;
		endcase
	endtask

	// unused upper bits carry random junk
	task automatic configure(input int color, input int l, input int t, input int r,
			input int b);
		logic [blr_pkg::CFG_DATA_W-1:0] junk;
		junk = $urandom;
		write_reg(blr_pkg::REG_PEN_COLOR, {junk[31:24], color[23:0]});
		write_reg(blr_pkg::REG_CLIP_LEFT, {junk[31:12], l[11:0]});
		write_reg(blr_pkg::REG_CLIP_TOP, {junk[19:0], t[11:0]});
		write_reg(blr_pkg::REG_CLIP_RIGHT, {junk[27:8], r[11:0]});
		write_reg(blr_pkg::REG_CLIP_BOTTOM, {junk[23:4], b[11:0]});
	endtask

	task automatic wait_for_drain;
		do @(posedge clk); while (pending_cmds.size() != 0 || expected_pixels.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic queue_random_traffic(input int count);
		int n, sx, sy, ex, ey, span, major, steps;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_cmd(blr_pkg::line_op_t'($urandom_range(0, 1)), $urandom, $urandom,
					$urandom, $urandom);
				n++;
			end else begin
				if ($urandom_range(0, 1)) begin
					sx = int'($urandom_range(0, 4095)) + COORD_MIN;
					sy = int'($urandom_range(0, 4095)) + COORD_MIN;
				end else begin
					sx = int'($urandom_range(0, 80)) - 40;
					sy = int'($urandom_range(0, 80)) - 40;
				end
				case ($urandom_range(0, 19))
					0:       span = 4095;
					1, 2, 3: span = 60;
					default: span = 12;
				endcase
				ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
				ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
				major = (ex > sx ? ex - sx : sx - ex);
				if ((ey > sy ? ey - sy : sy - ey) > major)
					major = ey > sy ? ey - sy : sy - ey;
				steps = major > 0 ? major - 1 : 0;
				if (steps > 0 && (span == 4095 || $urandom_range(0, 6) == 0))
					steps = $urandom_range(0, steps > 40 ? 40 : steps);
				else if ($urandom_range(0, 9) == 0)
					steps += $urandom_range(1, 3);
				queue_cmd(blr_pkg::CMD_START, sx, sy, ex, ey);
				repeat (steps)
					queue_cmd(blr_pkg::CMD_NEXT, $urandom, $urandom, $urandom, $urandom);
				n += steps + 1;
			end
		end
	endtask

	// command sender: bursts of random length, random gaps between them
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				rasterize_step(pending_cmds.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0)
					gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			end
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				if (burst_left == 0)
					burst_left = $urandom_range(1, 48);
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {pending_cmds[0].ey, pending_cmds[0].ex, pending_cmds[0].sy,
					pending_cmds[0].sx};
				s_axis_tuser <= pending_cmds[0].op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// pixel receiver with its own stall pattern
	logic [31:0] stall_pat = '1;
	logic [4:0]  stall_pos = '0;
	always @(posedge clk) begin
		pixel_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.valid = m_axis_tuser[0];
				got.x = m_axis_tdata[11:0];
				got.y = m_axis_tdata[23:12];
				got.color = m_axis_tdata[47:24];
				got.in_clip = m_axis_tuser[1];
				got.last = m_axis_tlast;
				if (expected_pixels.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected pixel transfer: valid=%0b x=%0d y=%0d",
							got.valid, got.x, got.y);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					if (got.valid !== want.valid || got.x !== want.x || got.y !== want.y ||
							got.color !== want.color || got.in_clip !== want.in_clip ||
							got.last !== want.last) begin
						if (mismatches < 10) begin
							$display("pixel mismatch: expected valid=%0b x=%0d y=%0d %s",
								want.valid, want.x, want.y, "");
							$display("  color=%06h inside=%0b last=%0b",
								want.color, want.in_clip, want.last);
							$display("  got valid=%0b x=%0d y=%0d color=%06h inside=%0b last=%0b",
								got.valid, got.x, got.y, got.color, got.in_clip, got.last);
						end
						mismatches++;
					end
				end
			end
			if (stall_pos == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pat = '1;
					1:       stall_pat = $urandom;
					default: stall_pat = $urandom | $urandom;
				endcase
			end
			m_axis_tready <= stall_pat[stall_pos];
			stall_pos <= stall_pos + 1'b1;
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int edge_l, edge_t;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset clip rectangle and color
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		queue_cmd(blr_pkg::CMD_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
		queue_cmd(blr_pkg::CMD_NEXT, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		// new line while one is running, both directions negative
		queue_cmd(blr_pkg::CMD_START, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		// equal endpoints draw nothing
		queue_cmd(blr_pkg::CMD_START, 5, 5, 5, 5);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		// horizontal, runs to the end and past it
		queue_cmd(blr_pkg::CMD_START, 0, 0, 3, 0);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		// vertical upward
		queue_cmd(blr_pkg::CMD_START, 0, 0, 0, -3);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		// shallow slope toward negative x
		queue_cmd(blr_pkg::CMD_START, 10, 3, 3, 5);
		repeat (6) queue_cmd(blr_pkg::CMD_NEXT, 0, 0, 0, 0);
		wait_for_drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			edge_l = int'($urandom_range(0, 60)) - 40;
			edge_t = int'($urandom_range(0, 60)) - 40;
			case (ph)
				0: begin
					configure(24'hFFFFFF, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
					write_reg(REG_UNMAPPED, $urandom);
				end
				1: configure(0, 0, 0, 0, 0);
				2: configure($urandom, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
				default: configure($urandom, edge_l, edge_t,
					edge_l + int'($urandom_range(0, 70)) - 10,
					edge_t + int'($urandom_range(0, 70)) - 10);
			endcase
			queue_random_traffic(PHASE_ITEMS);
			wait_for_drain();
		end

		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== bresenham_line_rasterizer.f =====
hw/rtl/blr_pkg.sv
hw/rtl/blr_apb_regs.sv
hw/rtl/bresenham_line_rasterizer.sv
tb/testbench.sv
